// ===== hw/rtl/rrb_pkg.sv =====
// Shared types and constants for the record ring buffer.
`timescale 1ns / 1ps
`default_nettype none

package rrb_pkg;

  typedef enum logic [1:0] {
    ACT_BEGIN   = 2'd0,
    ACT_PAYLOAD = 2'd1,
    ACT_POP     = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_e;

  localparam logic [7:0]  TYPE_BATCH = 8'd1;
  localparam logic [7:0]  TYPE_TABLE = 8'd2;
  localparam logic [15:0] GAP_LIMIT  = 16'd1000;
  localparam int unsigned HDR_BYTES  = 3;

  localparam int unsigned S_TDATA_W = 64;
  localparam int unsigned S_TUSER_W = 3;
  localparam int unsigned M_TDATA_W = 152;

endpackage

`default_nettype wire

// ===== hw/rtl/rrb_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module rrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/record_ring_buffer_with_gap_count.sv =====
// Record ring buffer: admits whole records into a byte ring, pops bytes, keeps stream counters.
//
//  channel  | dir | handshake               | contents
//  s_axis   | in  | tvalid/tready           | tuser: action, record_kind; tdata: header + byte
//  m_axis   | out | tvalid/tready           | tuser: accepted; tdata: popped byte + counters
//  apb      | in  | psel/penable/pready     | register 0: capture_enabled
//
// Payload byte, refused begin, ignored item and clear: accepted in S_IDLE, then S_FIN loads the result.
// Admitted begin: S_HDR1 and S_HDR2 follow; the three header bytes go through the single RAM write port.
// Pop: S_POPRD takes the byte from the registered RAM read port, then S_FIN loads the result.
// One transaction is processed at a time; a new one is accepted while a result waits on m_axis.
// A stalled m_axis holds the block in its final state until the result register frees up.
// Reset clears pointers and counters; the ring RAM itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module record_ring_buffer_with_gap_count
  import rrb_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 16384
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // [15:0] record_len, [31:16] sequence_number, [39:32] frame_count,
  // [55:40] gateway_drops, [63:56] data_byte
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // [1:0] action, [2] record_kind
  input  wire logic [S_TUSER_W-1:0] s_axis_tuser_i,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // [7:0] out_byte, [21:8] used_bytes, [53:22] dropped_records, [69:54] gap_packets,
  // [101:70] frames_total, [117:102] last_gateway_drops, [149:118] bytes_popped, zero pad
  output logic [M_TDATA_W-1:0]      m_axis_tdata_o,
  // [0] accepted
  output logic                      m_axis_tuser_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned CW = (AW + 1 > 17) ? AW + 1 : 17;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HDR1  = 3'd1;
  localparam logic [2:0] S_HDR2  = 3'd2;
  localparam logic [2:0] S_POPRD = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] p);
    return (p == AW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [2:0]           state_q, state_d;
  logic [AW-1:0]        wp_q, wp_d, ch_q, ch_d, rt_q, rt_d;
  logic [15:0]          rem_q, rem_d, len_q, len_d;
  logic                 have_seq_q, have_seq_d;
  logic [15:0]          last_seq_q, last_seq_d;
  logic [31:0]          drop_q, drop_d;
  logic [15:0]          gap_q, gap_d;
  logic [31:0]          frames_q, frames_d;
  logic [15:0]          gwd_q, gwd_d;
  logic [31:0]          pop_q, pop_d;
  logic                 cap_q;
  logic                 acc_q, acc_d;
  logic [7:0]           obyte_q, obyte_d;
  logic                 m_valid_q, m_valid_d;
  logic [M_TDATA_W-1:0] m_tdata_q, m_tdata_d;
  logic                 m_tuser_q, m_tuser_d;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr;
  logic [7:0]           ram_wdata, ram_rdata;

  action_e              act;
  logic                 kind;
  logic [15:0]          in_len, in_seq, in_gwd, missed;
  logic [7:0]           in_fcount, in_byte;
  logic                 s_fire, load_out;
  logic [CW-1:0]        used, free_b, need;

  assign act       = action_e'(s_axis_tuser_i[1:0]);
  assign kind      = s_axis_tuser_i[2];
  assign in_len    = s_axis_tdata_i[15:0];
  assign in_seq    = s_axis_tdata_i[31:16];
  assign in_fcount = s_axis_tdata_i[39:32];
  assign in_gwd    = s_axis_tdata_i[55:40];
  assign in_byte   = s_axis_tdata_i[63:56];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign load_out        = (state_q == S_FIN) && (!m_valid_q || m_axis_tready_i);

  assign used   = (ch_q >= rt_q) ? CW'(ch_q) - CW'(rt_q)
                                 : CW'(RING_DEPTH) - CW'(rt_q) + CW'(ch_q);
  assign free_b = CW'(RING_DEPTH - 1) - used;
  assign need   = CW'(in_len) + CW'(HDR_BYTES);
  assign missed = in_seq - last_seq_q - 16'd1;

  // APB register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, cap_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      cap_q <= pwdata[0];
    end
  end

  always_comb begin
    state_d    = state_q;
    wp_d       = wp_q;
    ch_d       = ch_q;
    rt_d       = rt_q;
    rem_d      = rem_q;
    len_d      = len_q;
    have_seq_d = have_seq_q;
    last_seq_d = last_seq_q;
    drop_d     = drop_q;
    gap_d      = gap_q;
    frames_d   = frames_q;
    gwd_d      = gwd_q;
    pop_d      = pop_q;
    acc_d      = acc_q;
    obyte_d    = obyte_q;
    ram_we     = 1'b0;
    ram_waddr  = wp_q;
    ram_wdata  = 8'd0;
    ram_re     = 1'b0;
    m_valid_d  = m_valid_q && !m_axis_tready_i;
    m_tdata_d  = m_tdata_q;
    m_tuser_d  = m_tuser_q;

    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          acc_d   = 1'b0;
          obyte_d = 8'd0;
          state_d = S_FIN;
          case (act)
            ACT_BEGIN: begin
              if (cap_q) begin
                wp_d  = ch_q;
                rem_d = 16'd0;
                if (!kind) begin
                  if (have_seq_q && (in_seq != last_seq_q + 16'd1) && (missed < GAP_LIMIT)) begin
                    gap_d = gap_q + missed;
                  end
                  last_seq_d = in_seq;
                  have_seq_d = 1'b1;
                  gwd_d      = in_gwd;
                  frames_d   = frames_q + 32'(in_fcount);
                end
                if (free_b < need) begin
                  drop_d = drop_q + 32'd1;
                end else begin
                  ram_we    = 1'b1;
                  ram_waddr = ch_q;
                  ram_wdata = kind ? TYPE_TABLE : TYPE_BATCH;
                  wp_d      = adv(ch_q);
                  len_d     = in_len;
                  rem_d     = in_len;
                  acc_d     = 1'b1;
                  state_d   = S_HDR1;
                end
              end
            end
            ACT_PAYLOAD: begin
              if (cap_q && (rem_q != 16'd0)) begin
                ram_we    = 1'b1;
                ram_waddr = wp_q;
                ram_wdata = in_byte;
                wp_d      = adv(wp_q);
                rem_d     = rem_q - 16'd1;
                if (rem_q == 16'd1) begin
                  ch_d = adv(wp_q);
                end
                acc_d = 1'b1;
              end
            end
            ACT_POP: begin
              if (ch_q != rt_q) begin
                ram_re  = 1'b1;
                rt_d    = adv(rt_q);
                pop_d   = pop_q + 32'd1;
                acc_d   = 1'b1;
                state_d = S_POPRD;
              end
            end
            ACT_CLEAR: begin
              wp_d       = '0;
              ch_d       = '0;
              rt_d       = '0;
              rem_d      = 16'd0;
              have_seq_d = 1'b0;
              last_seq_d = 16'd0;
              drop_d     = 32'd0;
              gap_d      = 16'd0;
              frames_d   = 32'd0;
              gwd_d      = 16'd0;
              pop_d      = 32'd0;
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end
      end
      S_HDR1: begin
        ram_we    = 1'b1;
        ram_wdata = len_q[7:0];
        wp_d      = adv(wp_q);
        state_d   = S_HDR2;
      end
      S_HDR2: begin
        ram_we    = 1'b1;
        ram_wdata = len_q[15:8];
        wp_d      = adv(wp_q);
        if (len_q == 16'd0) begin
          ch_d = adv(wp_q);
        end
        state_d = S_FIN;
      end
      S_POPRD: begin
        obyte_d = ram_rdata;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (load_out) begin
          m_valid_d = 1'b1;
          m_tuser_d = acc_q;
          m_tdata_d = {2'b00, pop_q, gwd_q, frames_q, gap_q, drop_q, used[13:0], obyte_q};
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      wp_q       <= '0;
      ch_q       <= '0;
      rt_q       <= '0;
      rem_q      <= 16'd0;
      have_seq_q <= 1'b0;
      last_seq_q <= 16'd0;
      drop_q     <= 32'd0;
      gap_q      <= 16'd0;
      frames_q   <= 32'd0;
      gwd_q      <= 16'd0;
      pop_q      <= 32'd0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      wp_q       <= wp_d;
      ch_q       <= ch_d;
      rt_q       <= rt_d;
      rem_q      <= rem_d;
      have_seq_q <= have_seq_d;
      last_seq_q <= last_seq_d;
      drop_q     <= drop_d;
      gap_q      <= gap_d;
      frames_q   <= frames_d;
      gwd_q      <= gwd_d;
      pop_q      <= pop_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q     <= len_d;
    acc_q     <= acc_d;
    obyte_q   <= obyte_d;
    m_tdata_q <= m_tdata_d;
    m_tuser_q <= m_tuser_d;
  end

  rrb_ram #(
    .WIDTH(8),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rt_q),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_tdata_q;
  assign m_axis_tuser_o  = m_tuser_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used <= CW'(RING_DEPTH - 1))
    else $error("committed byte count exceeds ring capacity");

  a_hdr_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_HDR1 |=> state_q == S_HDR2)
    else $error("header write sequence broken");

  a_pop_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POPRD |-> $past(ram_re))
    else $error("pop data taken without a RAM read");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == S_FIN))
    else $error("result loaded outside the final state");

endmodule

`default_nettype wire

// ===== tb/record_ring_buffer_with_gap_count_tb.sv =====
// Self-checking stream testbench for the record ring buffer with gap count.
`timescale 1ns / 1ps

import rrb_pkg::*;

typedef struct packed {
  action_e     act;
  logic        kind;
  logic [15:0] len;
  logic [15:0] seq;
  logic [7:0]  frames;
  logic [15:0] gw_drops;
  logic [7:0]  data;
} stream_item_t;

typedef struct packed {
  logic        accepted;
  logic [7:0]  out_byte;
  logic [13:0] used;
  logic [31:0] dropped;
  logic [15:0] gaps;
  logic [31:0] frames;
  logic [15:0] gw_drops;
  logic [31:0] popped;
} ring_status_t;

class ring_status_predictor #(int unsigned DEPTH = 16384);
  logic [7:0]   ring [DEPTH];
  int unsigned  wr_ptr;
  int unsigned  commit_ptr;
  int unsigned  rd_ptr;
  logic [15:0]  remaining;
  bit           have_seq;
  logic [15:0]  last_seq;
  logic [31:0]  drops;
  logic [15:0]  gaps;
  logic [31:0]  frames;
  logic [15:0]  gw_copy;
  logic [31:0]  popped;
  bit           capture;
  int           errors;
  ring_status_t status_due[$];

  function new();
    clear_state();
    capture = 1'b0;
    errors = 0;
  endfunction

  function void clear_state();
    wr_ptr = 0;
    commit_ptr = 0;
    rd_ptr = 0;
    remaining = '0;
    have_seq = 1'b0;
    last_seq = '0;
    drops = '0;
    gaps = '0;
    frames = '0;
    gw_copy = '0;
    popped = '0;
  endfunction

  function int unsigned used_bytes();
    if (commit_ptr >= rd_ptr) return commit_ptr - rd_ptr;
    return DEPTH - rd_ptr + commit_ptr;
  endfunction

  function int unsigned free_bytes();
    return DEPTH - used_bytes() - 1;
  endfunction

  function int pending();
    return status_due.size();
  endfunction

  function void store(logic [7:0] b);
    ring[wr_ptr] = b;
    wr_ptr = (wr_ptr + 1) % DEPTH;
  endfunction

  // Returns 1 when the transaction had an effect on the block's state.
  function bit accept_item(stream_item_t it);
    ring_status_t st;
    logic [15:0]  missed;
    int unsigned  need;
    st = '0;
    case (it.act)
      ACT_BEGIN: begin
        if (capture) begin
          wr_ptr = commit_ptr;
          remaining = '0;
          if (it.kind == 1'b0) begin
            if (have_seq && it.seq != 16'(last_seq + 16'd1)) begin
              missed = it.seq - last_seq - 16'd1;
              if (missed != 16'd0 && missed < GAP_LIMIT) gaps = gaps + missed;
            end
            last_seq = it.seq;
            have_seq = 1'b1;
            gw_copy = it.gw_drops;
            frames = frames + 32'(it.frames);
          end
          need = HDR_BYTES + it.len;
          if (free_bytes() < need) begin
            drops = drops + 32'd1;
          end else begin
            store(it.kind ? TYPE_TABLE : TYPE_BATCH);
            store(it.len[7:0]);
            store(it.len[15:8]);
            remaining = it.len;
            if (it.len == 16'd0) commit_ptr = wr_ptr;
            st.accepted = 1'b1;
          end
        end
      end
      ACT_PAYLOAD: begin
        if (capture && remaining != 16'd0) begin
          store(it.data);
          remaining = remaining - 16'd1;
          if (remaining == 16'd0) commit_ptr = wr_ptr;
          st.accepted = 1'b1;
        end
      end
      ACT_POP: begin
        if (commit_ptr != rd_ptr) begin
          st.out_byte = ring[rd_ptr];
          rd_ptr = (rd_ptr + 1) % DEPTH;
          popped = popped + 32'd1;
          st.accepted = 1'b1;
        end
      end
      default: clear_state();
    endcase
    st.used = 14'(used_bytes());
    st.dropped = drops;
    st.gaps = gaps;
    st.frames = frames;
    st.gw_drops = gw_copy;
    st.popped = popped;
    status_due.push_back(st);
    return st.accepted || it.act == ACT_CLEAR || (it.act == ACT_BEGIN && capture);
  endfunction

  function void field_check(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $display("%0t: %s expected %0h got %0h", $time, name, exp, act);
      errors++;
    end
  endfunction

  function void match_status(ring_status_t got);
    ring_status_t exp;
    if (status_due.size() == 0) begin
      $display("%0t: result with nothing outstanding, got %0h", $time, got);
      errors++;
      return;
    end
    exp = status_due.pop_front();
    field_check("accepted", 32'(exp.accepted), 32'(got.accepted));
    field_check("out_byte", 32'(exp.out_byte), 32'(got.out_byte));
    field_check("used_bytes", 32'(exp.used), 32'(got.used));
    field_check("dropped_records", exp.dropped, got.dropped);
    field_check("gap_packets", 32'(exp.gaps), 32'(got.gaps));
    field_check("frames_total", exp.frames, got.frames);
    field_check("last_gateway_drops", 32'(exp.gw_drops), 32'(got.gw_drops));
    field_check("bytes_popped", exp.popped, got.popped);
  endfunction
endclass

module record_ring_buffer_with_gap_count_tb;
  localparam int unsigned RING_DEPTH      = 16384;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned ITEMS_PER_PHASE = 150;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam logic [2:0]  ADDR_CAPTURE    = 3'd0;

  localparam int SEND_IDLE [4] = '{0, 62, 0, 20};
  localparam int RECV_STALL [4] = '{0, 0, 62, 20};

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_valid = 1'b0;
  logic [S_TDATA_W-1:0] s_data = '0;
  logic [S_TUSER_W-1:0] s_user = '0;
  logic                 m_ready = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [2:0]           paddr = '0;
  logic [31:0]          pwdata = '0;

  logic                 s_ready;
  logic                 m_valid;
  logic [M_TDATA_W-1:0] m_data;
  logic                 m_user;
  logic [31:0]          prdata;
  logic                 pready;

  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_cycles = 0;
  int unsigned cycles = 0;
  int          effective_items = 0;
  logic [15:0] next_seq;

  ring_status_predictor #(RING_DEPTH) sb;

  record_ring_buffer_with_gap_count #(
    .RING_DEPTH(RING_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_cycles != 0) hold_cycles <= hold_cycles - 1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) begin
      sb.match_status({m_user, m_data[7:0], m_data[21:8], m_data[53:22],
                       m_data[69:54], m_data[101:70], m_data[117:102], m_data[149:118]});
    end
    if (hold_cycles != 0) m_ready <= 1'b0;
    else m_ready <= ($urandom_range(99) >= stall_pct);
  end

  function stream_item_t make_item(action_e act, logic kind, logic [15:0] len,
                                   logic [15:0] seq, logic [7:0] frames,
                                   logic [15:0] gw, logic [7:0] data);
    return '{act, kind, len, seq, frames, gw, data};
  endfunction

  function stream_item_t random_item(action_e act);
    return '{act, 1'($urandom_range(1)), 16'($urandom_range(65535)),
             16'($urandom_range(65535)), 8'($urandom_range(255)),
             16'($urandom_range(65535)), 8'($urandom_range(255))};
  endfunction

  // Mostly in order, with short gaps, long jumps and random values mixed in.
  function logic [15:0] next_sequence();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 80) next_seq = next_seq + 16'd1;
    else if (p < 90) next_seq = next_seq + 16'($urandom_range(999, 2));
    else if (p < 95) next_seq = next_seq + 16'($urandom_range(65534, 1000));
    else next_seq = 16'($urandom_range(65535));
    return next_seq;
  endfunction

  task send_item(stream_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_valid <= 1'b1;
    s_user <= {it.kind, it.act};
    s_data <= {it.data, it.gw_drops, it.frames, it.seq, it.len};
    do @(posedge clk_i); while (s_ready !== 1'b1);
    if (sb.accept_item(it)) effective_items++;
  endtask

  task wait_idle();
    s_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task set_capture(logic value);
    wait_idle();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_CAPTURE;
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.capture = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task run_group();
    stream_item_t it;
    int unsigned  pick;
    int unsigned  len_pick;
    int unsigned  n;
    pick = $urandom_range(99);
    if (pick < 50) begin
      it = random_item(ACT_BEGIN);
      it.kind = ($urandom_range(99) < 70) ? 1'b0 : 1'b1;
      len_pick = $urandom_range(99);
      if (len_pick < 85) it.len = 16'($urandom_range(12));
      else if (len_pick < 90) it.len = 16'($urandom_range(40, 13));
      else if (len_pick < 95) it.len = 16'($urandom_range(65535, RING_DEPTH));
      else it.len = 16'(sb.free_bytes() - HDR_BYTES + $urandom_range(1));
      if (it.kind == 1'b0) it.seq = next_sequence();
      send_item(it);
      if (it.len <= 16'd40) begin
        n = it.len;
        // occasionally leave the record unfinished
        if (n != 0 && $urandom_range(9) == 0) n = $urandom_range(n - 1);
        repeat (n) begin
          if ($urandom_range(99) < 15) send_item(random_item(ACT_POP));
          send_item(random_item(ACT_PAYLOAD));
        end
      end
    end else if (pick < 80) begin
      repeat ($urandom_range(8, 1)) send_item(random_item(ACT_POP));
    end else if (pick < 98) begin
      send_item(random_item(action_e'($urandom_range(2))));
    end else begin
      send_item(random_item(ACT_CLEAR));
    end
  endtask

  initial begin
    int phase_start;
    sb = new();
    next_seq = 16'($urandom_range(65535));
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // capture off: begin and payload ignored, pop on empty ring
    send_item(make_item(ACT_BEGIN, 1'b0, 16'd3, 16'd100, 8'd7, 16'd9, 8'h00));
    send_item(make_item(ACT_PAYLOAD, 1'b0, 16'd0, 16'd0, 8'd0, 16'd0, 8'h77));
    send_item(make_item(ACT_POP, 1'b0, 16'd0, 16'd0, 8'd0, 16'd0, 8'h00));
    set_capture(1'b1);
    // zero length record, sequence wrap, field extremes
    send_item(make_item(ACT_BEGIN, 1'b0, 16'd0, 16'hFFFF, 8'hFF, 16'hFFFF, 8'h00));
    send_item(make_item(ACT_BEGIN, 1'b0, 16'd2, 16'h0000, 8'h00, 16'h0000, 8'h00));
    send_item(make_item(ACT_PAYLOAD, 1'b0, 16'd0, 16'd0, 8'd0, 16'd0, 8'hFF));
    send_item(make_item(ACT_PAYLOAD, 1'b0, 16'd0, 16'd0, 8'd0, 16'd0, 8'h00));
    send_item(make_item(ACT_PAYLOAD, 1'b0, 16'd0, 16'd0, 8'd0, 16'd0, 8'h99));
    send_item(make_item(ACT_BEGIN, 1'b1, 16'd3, 16'h1234, 8'd3, 16'd4, 8'h00));
    send_item(make_item(ACT_PAYLOAD, 1'b0, 16'd0, 16'd0, 8'd0, 16'd0, 8'hA5));
    // capture dropped with a record open
    set_capture(1'b0);
    send_item(make_item(ACT_PAYLOAD, 1'b0, 16'd0, 16'd0, 8'd0, 16'd0, 8'h5A));
    set_capture(1'b1);
    send_item(make_item(ACT_PAYLOAD, 1'b0, 16'd0, 16'd0, 8'd0, 16'd0, 8'h3C));
    send_item(make_item(ACT_PAYLOAD, 1'b0, 16'd0, 16'd0, 8'd0, 16'd0, 8'hC3));
    // small gap, then abandon an open record with a jump past the gap limit
    send_item(make_item(ACT_BEGIN, 1'b0, 16'd4, 16'd5, 8'd10, 16'd20, 8'h00));
    send_item(make_item(ACT_PAYLOAD, 1'b0, 16'd0, 16'd0, 8'd0, 16'd0, 8'h11));
    send_item(make_item(ACT_BEGIN, 1'b0, 16'd1, 16'd1006, 8'd1, 16'd21, 8'h00));
    send_item(make_item(ACT_PAYLOAD, 1'b0, 16'd0, 16'd0, 8'd0, 16'd0, 8'h22));
    // refused batch still tracked; repeated sequence number
    send_item(make_item(ACT_BEGIN, 1'b0, 16'hFFFF, 16'd2005, 8'd2, 16'd22, 8'h00));
    send_item(make_item(ACT_BEGIN, 1'b0, 16'd0, 16'd2005, 8'd3, 16'd23, 8'h00));
    repeat (3) send_item(make_item(ACT_POP, 1'b0, 16'd0, 16'd0, 8'd0, 16'd0, 8'h00));
    send_item(make_item(ACT_CLEAR, 1'b0, 16'd0, 16'd0, 8'd0, 16'd0, 8'h00));
    // admission boundary on an empty ring
    send_item(make_item(ACT_BEGIN, 1'b1, 16'(RING_DEPTH - 4), 16'd0, 8'd0, 16'd0, 8'h00));
    send_item(make_item(ACT_BEGIN, 1'b1, 16'(RING_DEPTH - 3), 16'd0, 8'd0, 16'd0, 8'h00));

    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      send_idle_pct = SEND_IDLE[phase];
      stall_pct = RECV_STALL[phase];
      if (phase == 0) hold_cycles <= HOLD_OFF_CYCLES;
      phase_start = effective_items;
      while (effective_items - phase_start < ITEMS_PER_PHASE) run_group();
      set_capture(1'b0);
      repeat (6) run_group();
      set_capture(1'b1);
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
